// ===== rtl/ftvd_pkg.sv =====
// shared types and constants for the fan triangulation vertex dedup block
package ftvd_pkg;

  localparam int KeyW       = 24;
  localparam int CntW       = 23;
  localparam int NumBuckets = 4096;
  localparam int BucketW    = $clog2(NumBuckets);

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    OP_CORNER = 1'b0,
    OP_NEW_MESH = 1'b1
  } opcode_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_PICK,
    S_TEST,
    S_HASH,
    S_HEAD,
    S_LINK,
    S_NODE,
    S_CMP,
    S_INSERT,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [KeyW-1:0] p;
    logic [KeyW-1:0] t;
    logic [KeyW-1:0] n;
  } triple_t;

  // negative index counts back from the end
  function automatic logic [KeyW-1:0] resolve_idx(input logic [KeyW-1:0] idx,
                                                  input logic [CntW-1:0] cnt);
    logic [KeyW-1:0] r;
    begin
      r = idx;
      if (idx[KeyW-1]) r = {1'b0, cnt} + idx + KeyW'(1);
      return r;
    end
  endfunction

  // signed compare: key above count means absent
  function automatic logic [KeyW-1:0] clamp_idx(input logic [KeyW-1:0] k,
                                                input logic [CntW-1:0] cnt);
    logic [KeyW-1:0] r;
    begin
      r = k;
      if ($signed(k) > $signed({1'b0, cnt})) r = '0;
      return r;
    end
  endfunction

endpackage

// ===== rtl/ftvd_hash.sv =====
// iterative bucket hash, one multiply-add per cycle
module ftvd_hash import ftvd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  triple_t            key,
  output logic               done,
  output logic [BucketW-1:0] bucket
);

  logic [31:0] h;
  logic [1:0]  step;
  logic        busy;
  logic [KeyW-1:0] term;
  logic [31:0] term_ext;

  always_comb begin
    case (step)
      2'd0: term = key.p;
      2'd1: term = key.t;
      default: term = key.n;
    endcase
  end

  // sign-extend to 32 bits as the index is a signed int
  assign term_ext = {{(32-KeyW){term[KeyW-1]}}, term};

  always_ff @(posedge clk) begin
    if (rst) begin
      h    <= '0;
      step <= '0;
      busy <= 1'b0;
    end else if (start) begin
      h    <= '0;
      step <= '0;
      busy <= 1'b1;
    end else if (busy) begin
      // times 31 as shift and subtract
      h    <= (h << 5) - h + term_ext;
      step <= step + 2'd1;
      if (step == 2'd2) busy <= 1'b0;
    end
  end

  // high in the cycle of the last step, bucket is valid after that edge
  assign done   = busy && (step == 2'd2);
  assign bucket = h[BucketW-1:0];

endmodule

// ===== rtl/fan_triangulate_vertex_dedup.sv =====
// top level: fan triangulation with hashed vertex dedup
//
// channel | dir | fields
// s_axis  | in  | tuser: opcode, first_of_face; tdata: pos/uv/normal index, counts
// m_axis  | out | tdata: vertex_index, refs; tuser: created, status; tlast = last
//
// a corner with no triangle, or a dropped corner, is taken with no lookup
// a triangle corner starts three lookups; a lookup tests the position, hashes,
// reads the bucket head, walks the chain comparing nodes and inserts a new vertex
// on a miss, while an invalid position goes straight to the output; the shared hash unit
// and the single node memory port serialise the lookups; after reset, and after a new-mesh
// item, a clearing pass walks the bucket heads one per cycle while s_axis_tready stays low
// a result waits in the output register; the sequencer stalls until taken
module fan_triangulate_vertex_dedup import ftvd_pkg::*; #(
  parameter int MAX_VERTICES     = 65536,
  parameter int MAX_FACE_CORNERS = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // opcode, first_of_face
  input  logic [1:0]   s_axis_tuser,
  // pos_index, uv_index, normal_index, pos_count, uv_count, normal_count, zero fill
  input  logic [143:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // created, status
  output logic [2:0]   m_axis_tuser,
  // vertex_index, pos_ref, uv_ref, normal_ref
  output logic [87:0]  m_axis_tdata,
  output logic         m_axis_tlast
);

  localparam int NodeW   = $clog2(MAX_VERTICES);
  localparam int LinkW   = NodeW + 1;
  localparam int CornerW = $clog2(MAX_FACE_CORNERS + 1);

  // unpack input item
  opcode_t         in_op;
  logic            in_first;
  logic [KeyW-1:0] in_p, in_t, in_n;
  logic [CntW-1:0] in_pc, in_tc, in_nc;
  triple_t         in_key;
  assign in_op    = opcode_t'(s_axis_tuser[0]);
  assign in_first = s_axis_tuser[1];
  assign in_p     = s_axis_tdata[23:0];
  assign in_t     = s_axis_tdata[47:24];
  assign in_n     = s_axis_tdata[71:48];
  assign in_pc    = s_axis_tdata[94:72];
  assign in_tc    = s_axis_tdata[117:95];
  assign in_nc    = s_axis_tdata[140:118];
  assign in_key   = {resolve_idx(in_p, in_pc), resolve_idx(in_t, in_tc),
                     resolve_idx(in_n, in_nc)};

  // memories: heads and links hold node number + 1, zero is empty
  logic [LinkW-1:0] heads [NumBuckets];
  triple_t          node_key [MAX_VERTICES];
  logic [LinkW-1:0] node_next [MAX_VERTICES];

  state_t state, state_next;
  logic [BucketW-1:0] clr_idx;
  logic [CornerW-1:0] corner_count, eff_count;
  logic               drop, emits;
  logic [LinkW-1:0]   vert_total;
  triple_t first_key, prev_key, prev_emit, pick_key, look, key_rd;
  logic [CntW-1:0] pc, tc, nc;
  logic [1:0] which;
  logic [LinkW-1:0] link, steps;
  logic [LinkW-1:0] head_rd, next_rd;
  logic [NodeW-1:0] link_node;
  logic [BucketW-1:0] bucket;
  logic hash_start, hash_done;
  logic pos_bad, accept, out_load, key_hit, do_insert;

  logic [15:0] r_vidx;
  logic        r_created;
  status_t     r_status;

  logic [87:0] out_data;
  logic [2:0]  out_user;
  logic        out_valid, out_last;

  ftvd_hash u_hash (
    .clk(clk), .rst(rst), .start(hash_start), .key(look), .done(hash_done),
    .bucket(bucket)
  );

  assign link_node = NodeW'(link - LinkW'(1));

  // corner position within the face once first_of_face is applied
  assign eff_count = in_first ? CornerW'(0) : corner_count;
  assign drop      = (eff_count >= CornerW'(MAX_FACE_CORNERS));
  assign emits     = (eff_count >= CornerW'(2));

  // triangle vertex order: first, previous, current
  always_comb begin
    case (which)
      2'd0: pick_key = first_key;
      2'd1: pick_key = prev_emit;
      default: pick_key = prev_key;
    endcase
  end

  assign pos_bad = ($signed(look.p) < $signed(KeyW'(1))) ||
                   ($signed(look.p) > $signed({1'b0, pc}));
  assign key_hit   = (key_rd == look);
  assign do_insert = (state == S_INSERT) && (vert_total != LinkW'(MAX_VERTICES));

  always_ff @(posedge clk) begin
    head_rd <= heads[bucket];
    key_rd  <= node_key[link_node];
    next_rd <= node_next[link_node];
    if (state == S_CLEAR) heads[clr_idx] <= '0;
    else if (do_insert) heads[bucket] <= vert_total + LinkW'(1);
    if (do_insert) begin
      // new node goes to the head of its chain
      node_key[vert_total[NodeW-1:0]]  <= look;
      node_next[vert_total[NodeW-1:0]] <= head_rd;
    end
  end

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = out_user;
  assign m_axis_tlast  = out_last;
  assign hash_start    = (state == S_TEST) && !pos_bad;
  assign out_load      = (state == S_OUT) && (!out_valid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr_idx == BucketW'(NumBuckets - 1)) state_next = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          if (in_op == OP_NEW_MESH) state_next = S_CLEAR;
          else if (!drop && emits) state_next = S_PICK;
        end
      end
      S_PICK: state_next = S_TEST;
      S_TEST: state_next = pos_bad ? S_OUT : S_HASH;
      S_HASH: if (hash_done) state_next = S_HEAD;
      S_HEAD: state_next = S_LINK;
      S_LINK: state_next = S_NODE;
      S_NODE: begin
        if (link == '0 || steps >= vert_total) state_next = S_INSERT;
        else state_next = S_CMP;
      end
      S_CMP: state_next = key_hit ? S_OUT : S_NODE;
      S_INSERT: state_next = S_OUT;
      S_OUT: if (out_load) state_next = (which == 2'd2) ? S_IDLE : S_PICK;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx      <= '0;
      corner_count <= '0;
      vert_total   <= '0;
      out_valid    <= 1'b0;
      out_last     <= 1'b0;
      out_data     <= '0;
      out_user     <= '0;
      which        <= '0;
      first_key    <= '0;
      prev_key     <= '0;
      prev_emit    <= '0;
      look         <= '0;
      pc           <= '0;
      tc           <= '0;
      nc           <= '0;
      link         <= '0;
      steps        <= '0;
      r_vidx       <= '0;
      r_created    <= 1'b0;
      r_status     <= ST_OK;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (m_axis_tready) out_valid <= 1'b0;
      case (state)
        S_CLEAR: clr_idx <= clr_idx + BucketW'(1);
        S_IDLE: if (accept) begin
          if (in_op == OP_NEW_MESH) begin
            clr_idx      <= '0;
            corner_count <= '0;
            vert_total   <= '0;
          end else if (!drop) begin
            if (eff_count == '0) first_key <= in_key;
            // old previous corner is kept for the middle triangle vertex
            prev_emit    <= prev_key;
            prev_key     <= in_key;
            corner_count <= eff_count + CornerW'(1);
            pc           <= in_pc;
            tc           <= in_tc;
            nc           <= in_nc;
            which        <= '0;
          end
        end
        // counts of the current item clamp texture and normal
        S_PICK: look <= {pick_key.p, clamp_idx(pick_key.t, tc), clamp_idx(pick_key.n, nc)};
        S_TEST: begin
          r_vidx    <= '0;
          r_created <= 1'b0;
          r_status  <= pos_bad ? ST_BAD_POS : ST_OK;
        end
        S_LINK: begin
          link  <= head_rd;
          steps <= '0;
        end
        S_CMP: begin
          if (key_hit) r_vidx <= 16'(link_node);
          else begin
            link  <= next_rd;
            steps <= steps + LinkW'(1);
          end
        end
        S_INSERT: begin
          if (vert_total == LinkW'(MAX_VERTICES)) r_status <= ST_FULL;
          else begin
            r_vidx     <= 16'(vert_total);
            r_created  <= 1'b1;
            vert_total <= vert_total + LinkW'(1);
          end
        end
        S_OUT: if (out_load) begin
          out_last <= (which == 2'd2);
          out_data <= {look.n, look.t, look.p, r_vidx};
          out_user <= {r_status, r_created};
          which    <= which + 2'd1;
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== test/fan_triangulate_vertex_dedup_tb.sv =====
// testbench for the fan triangulation vertex dedup block: queue-fed driver and scoreboard
module fan_triangulate_vertex_dedup_tb;
  import ftvd_pkg::*;

  localparam int NBUCK = 4096;
  localparam int MAXV = 65536;
  localparam int MAXC = 32;
  localparam int LIMIT = 600000;

  typedef struct {
    bit                 hold;
    opcode_t            op;
    logic               fof;
    logic signed [23:0] pi, ui, ni;
    logic [22:0]        pc, uc, nc;
  } corner_t;

  typedef struct {
    logic [15:0] vidx;
    logic        created;
    logic [23:0] p, t, n;
    status_t     st;
    logic        last;
  } vert_t;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [1:0]   s_axis_tuser = '0;
  logic [143:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [2:0]   m_axis_tuser;
  logic [87:0]  m_axis_tdata;
  logic         m_axis_tlast;

  fan_triangulate_vertex_dedup dut (.*);

  initial forever #2 clk = ~clk;

  // dedup model state
  int unsigned heads[NBUCK];
  int          key_p[MAXV], key_t[MAXV], key_n[MAXV];
  int unsigned nxt[MAXV];
  int unsigned vcount, ccount;
  int          first_k[3], prev_k[3];

  corner_t pending[$];
  vert_t   vert_q[$];
  corner_t cur;
  int      sent = 0, got = 0, errors = 0, cycles = 0, meshes = 0, bad_pos = 0, dedup_hits = 0;
  int      hold_left = 0;
  bit      held = 0, nxt_valid;

  function automatic logic [143:0] pack(corner_t c);
    return {3'b0, c.nc, c.uc, c.pc, c.ni, c.ui, c.pi};
  endfunction

  function automatic logic [1:0] pack_user(corner_t c);
    return {c.fof, c.op};
  endfunction

  function automatic int resolve(int idx, int cnt);
    return idx < 0 ? cnt + idx + 1 : idx;
  endfunction

  // look up one triangle vertex, insert when new
  function automatic void lookup_vertex(int k0, int k1, int k2, int pc, int uc, int nc,
                                        bit lst);
    vert_t       v;
    int          t, n;
    int unsigned h, b, link, steps, k;
    bit          found;
    t = k1 > uc ? 0 : k1;
    n = k2 > nc ? 0 : k2;
    v.vidx = 0; v.created = 0; v.st = ST_OK; v.last = lst;
    v.p = k0[23:0]; v.t = t[23:0]; v.n = n[23:0];
    if (k0 < 1 || k0 > pc) begin
      v.st = ST_BAD_POS;
      bad_pos++;
    end else begin
      h = 0;
      h = h * 31 + unsigned'(k0);
      h = h * 31 + unsigned'(t);
      h = h * 31 + unsigned'(n);
      b = h % NBUCK;
      link = heads[b];
      steps = 0;
      found = 0;
      while (link != 0 && steps < vcount && !found) begin
        k = link - 1;
        if (key_p[k] == k0 && key_t[k] == t && key_n[k] == n) begin
          v.vidx = k[15:0];
          found = 1;
          dedup_hits++;
        end else begin
          link = nxt[k];
          steps++;
        end
      end
      if (!found) begin
        if (vcount >= MAXV) v.st = ST_FULL;
        else begin
          k = vcount;
          key_p[k] = k0; key_t[k] = t; key_n[k] = n;
          nxt[k] = heads[b];
          heads[b] = k + 1;
          vcount = k + 1;
          v.vidx = k[15:0];
          v.created = 1;
        end
      end
    end
    vert_q.push_back(v);
  endfunction

  function automatic void predict_corner(corner_t c);
    int key[3];
    int pc, uc, nc;
    if (c.op == OP_NEW_MESH) begin
      foreach (heads[i]) heads[i] = 0;
      vcount = 0;
      ccount = 0;
      meshes++;
      return;
    end
    if (c.fof) ccount = 0;
    if (ccount >= MAXC) return;
    pc = int'({1'b0, c.pc}); uc = int'({1'b0, c.uc}); nc = int'({1'b0, c.nc});
    key[0] = resolve(int'(c.pi), pc);
    key[1] = resolve(int'(c.ui), uc);
    key[2] = resolve(int'(c.ni), nc);
    if (ccount == 0) first_k = key;
    if (ccount >= 2) begin
      lookup_vertex(first_k[0], first_k[1], first_k[2], pc, uc, nc, 0);
      lookup_vertex(prev_k[0], prev_k[1], prev_k[2], pc, uc, nc, 0);
      lookup_vertex(key[0], key[1], key[2], pc, uc, nc, 1);
    end
    prev_k = key;
    ccount++;
  endfunction

  function automatic corner_t mk(bit fof, int pi, int ui, int ni, int pc, int uc, int nc);
    corner_t c;
    c.hold = 0; c.op = OP_CORNER; c.fof = fof;
    c.pi = pi[23:0]; c.ui = ui[23:0]; c.ni = ni[23:0];
    c.pc = pc[22:0]; c.uc = uc[22:0]; c.nc = nc[22:0];
    return c;
  endfunction

  function automatic corner_t mk_mesh();
    corner_t c;
    c = mk($urandom_range(1), $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    c.op = OP_NEW_MESH;
    return c;
  endfunction

  function automatic corner_t mk_hold();
    corner_t c;
    c = mk(0, 0, 0, 0, 0, 0, 0);
    c.hold = 1;
    return c;
  endfunction

  // a small index pool so triples repeat and chains form
  function automatic int pick_idx(int cnt, bit may_absent);
    int r;
    r = $urandom_range(99);
    if (may_absent && r < 15) return 0;
    if (r < 35) return -$urandom_range(1, cnt > 0 ? cnt : 1);
    if (r < 40) return cnt + $urandom_range(1, 3);
    return $urandom_range(1, cnt > 0 ? cnt : 1);
  endfunction

  // driver: holds the item until accepted
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_corner(cur);
        sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        nxt_valid = 0;
        // drain pause marker
        if (pending.size() > 0 && pending[0].hold && vert_q.size() == 0)
          void'(pending.pop_front());
        if (pending.size() > 0 && !pending[0].hold &&
            ((sent >= 120 && sent < 190) || $urandom_range(99) >= 17)) begin
          cur = pending.pop_front();
          s_axis_tdata <= pack(cur);
          s_axis_tuser <= pack_user(cur);
          nxt_valid = 1;
        end
        s_axis_tvalid <= nxt_valid;
      end
    end
  end

  // receiver ready, with one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 0;
    end else if (got >= 60 && !held) begin
      held <= 1;
      hold_left <= 500;
      m_axis_tready <= 0;
    end else begin
      m_axis_tready <= (got >= 200 && got < 320) || $urandom_range(99) >= 17;
    end
  end

  // monitor: compare each result with the oldest expected vertex
  always @(posedge clk) begin
    vert_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got <= got + 1;
      if (vert_q.size() == 0) begin
        $error("unexpected result item %h", m_axis_tdata);
        errors++;
      end else begin
        e = vert_q.pop_front();
        if (m_axis_tdata[15:0] !== e.vidx) begin
          $error("vertex_index exp %0d got %0d", e.vidx, m_axis_tdata[15:0]); errors++;
        end
        if (m_axis_tuser[0] !== e.created) begin
          $error("created exp %0d got %0d", e.created, m_axis_tuser[0]); errors++;
        end
        if (m_axis_tdata[39:16] !== e.p) begin
          $error("pos_ref exp %h got %h", e.p, m_axis_tdata[39:16]); errors++;
        end
        if (m_axis_tdata[63:40] !== e.t) begin
          $error("uv_ref exp %h got %h", e.t, m_axis_tdata[63:40]); errors++;
        end
        if (m_axis_tdata[87:64] !== e.n) begin
          $error("normal_ref exp %h got %h", e.n, m_axis_tdata[87:64]); errors++;
        end
        if (m_axis_tuser[2:1] !== e.st) begin
          $error("status exp %0d got %0d", e.st, m_axis_tuser[2:1]); errors++;
        end
        if (m_axis_tlast !== e.last) begin
          $error("last exp %0d got %0d", e.last, m_axis_tlast); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int pc, uc, nc, k, r;
    foreach (heads[i]) heads[i] = 0;
    vcount = 0; ccount = 0;
    first_k = '{0, 0, 0}; prev_k = '{0, 0, 0};

    // directed: corner before any face start, extremes, negatives, bad positions
    pending.push_back(mk(0, 1, 0, 0, 8388607, 0, 0));
    pending.push_back(mk(0, -1, -1, -1, 8388607, 8388607, 8388607));
    pending.push_back(mk(0, 8388607, 8388607, 8388607, 8388607, 8388607, 8388607));
    pending.push_back(mk(0, -8388607, -8388607, -8388607, 0, 0, 0));
    pending.push_back(mk(1, 0, 5, 2, 4, 3, 3));
    pending.push_back(mk(0, 5, 1, 1, 4, 3, 3));
    pending.push_back(mk(0, 2, 9, -2, 4, 3, 3));
    pending.push_back(mk(0, 2, 9, -2, 4, 3, 3));
    pending.push_back(mk_mesh());
    pending.push_back(mk(1, 1, 1, 1, 3, 2, 2));
    pending.push_back(mk(0, 2, 1, 1, 3, 2, 2));
    pending.push_back(mk(0, 3, 1, 1, 3, 2, 2));
    // face longer than the corner limit
    pending.push_back(mk(1, 1, 0, 0, 6, 0, 0));
    for (int i = 1; i < 35; i++) pending.push_back(mk(0, i % 6 + 1, 0, 0, 6, 0, 0));

    // random: mostly well-formed faces, some noise and new meshes
    while (pending.size() < 282) begin
      r = $urandom_range(99);
      if (pending.size() > 170 && pending.size() < 176) pending.push_back(mk_hold());
      if (r < 78) begin
        pc = $urandom_range(3, 20); uc = $urandom_range(0, 8); nc = $urandom_range(0, 8);
        k = $urandom_range(3, 7);
        for (int i = 0; i < k; i++)
          pending.push_back(mk(i == 0, pick_idx(pc, 0), pick_idx(uc, 1), pick_idx(nc, 1),
                               pc, uc, nc));
      end else if (r < 95) begin
        pending.push_back(mk($urandom_range(1), $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom));
      end else begin
        pending.push_back(mk_mesh());
      end
    end

    repeat (10) @(posedge clk);
    rst <= 0;
    while (pending.size() > 0 || s_axis_tvalid) @(posedge clk);
    while (vert_q.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("covered %0d corners, %0d results, %0d new meshes", sent, got, meshes);
    $display("%0d invalid-position results, %0d dedup hits", bad_pos, dedup_hits);
    if (errors == 0 && vert_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
